// ===== rtl/core/fsqrt_pkg.sv =====
// shared types and constants for the single-precision square root unit
`timescale 1ns / 1ps
`default_nettype none
package fsqrt_pkg;
	localparam logic [31:0] EXP_MASK    = 32'h7f80_0000;
	localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
	localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
	localparam logic [31:0] DEFAULT_NAN = 32'hffc0_0000;
	localparam int RootBits  = 24;
	localparam int StageCnt  = 4;
	localparam int BitsPerSt = RootBits / StageCnt;

	typedef enum logic [1:0] {
		KIND_ROOT,
		KIND_FIXED
	} kind_t;

	// one word in flight through the digit-recurrence stages
	typedef struct packed {
		logic        vld;
		kind_t       kind;
		logic [31:0] fixed;
		logic        inv;
		logic [7:0]  ebiased;
		logic [49:0] rem;
		logic [47:0] rad;
		logic [23:0] root;
	} stage_t;

	// leading-zero count of a 24-bit significand, search over bit positions
	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		logic       found;
		n = 5'd0;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && v[i]) begin
				found = 1'b1;
				n = 5'(23 - i);
			end
		end
		return n;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/float32_square_root_unit.sv =====
// single-precision square root, one word per cycle through a digit pipeline when not stalled
// registered stages from input to output: prep, 4 root stages, round
// throughput: one word per cycle while the output is not stalled
// each root stage resolves 6 bits of the 24-bit root
// a stall freezes every stage together; the output register holds its word
// reset (arst_n low) clears all pipeline registers and the output valid; result payload is not reset
`timescale 1ns / 1ps
`default_nettype none
module float32_square_root_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        operand_bits_valid,
	output logic             operand_bits_stall,
	input  wire logic [31:0] operand_bits,
	output logic             root_valid,
	input  wire logic        root_stall,
	output logic [31:0]      root_bits,
	output logic             invalid_flag
);
	localparam int NS = fsqrt_pkg::StageCnt;
	localparam int BS = fsqrt_pkg::BitsPerSt;

	fsqrt_pkg::stage_t pipe_s[NS+1];
	fsqrt_pkg::stage_t next_s[NS+1];
	logic advance;

	assign advance = !(root_valid && root_stall);
	assign operand_bits_stall = !advance;

	// prep: classify, normalize, even exponent, place radicand
	always_comb begin
		logic [31:0] mag;
		logic [23:0] sig;
		logic [4:0]  lz;
		logic signed [9:0] uexp;
		next_s[0] = '0;
		uexp = '0;
		mag = operand_bits & ~fsqrt_pkg::SIGN_BIT;
		sig = {1'b0, mag[22:0]};
		lz = fsqrt_pkg::lzc24(sig);
		next_s[0].vld = operand_bits_valid;
		next_s[0].kind = fsqrt_pkg::KIND_FIXED;
		if (mag > fsqrt_pkg::EXP_MASK) begin
			next_s[0].fixed = operand_bits | fsqrt_pkg::QUIET_BIT;
			next_s[0].inv = !mag[22];
		end else if (operand_bits[31]) begin
			next_s[0].fixed = (mag == 32'd0) ? fsqrt_pkg::SIGN_BIT : fsqrt_pkg::DEFAULT_NAN;
			next_s[0].inv = (mag != 32'd0);
		end else if (mag == 32'd0 || mag == fsqrt_pkg::EXP_MASK) begin
			next_s[0].fixed = mag;
		end else begin
			next_s[0].kind = fsqrt_pkg::KIND_ROOT;
			if (mag[30:23] == 8'd0) begin
				sig = sig << lz;
				uexp = -10'sd126 - 10'(signed'({5'd0, lz}));
			end else begin
				sig = {1'b1, mag[22:0]};
				uexp = 10'(signed'({2'b0, mag[30:23]})) - 10'sd127;
			end
			if (uexp[0]) begin
				next_s[0].rad = {sig, 24'd0};
				uexp = uexp - 10'sd1;
			end else begin
				next_s[0].rad = {1'b0, sig, 23'd0};
			end
			next_s[0].ebiased = 8'((uexp >>> 1) + 10'sd127);
		end
	end

	// restoring digit recurrence, BS root bits per stage
	for (genvar g = 0; g < NS; g++) begin : g_stage
		always_comb begin
			logic [49:0] r;
			logic [49:0] trial;
			logic [47:0] rad;
			logic [23:0] q;
			next_s[g+1] = pipe_s[g];
			r = pipe_s[g].rem;
			rad = pipe_s[g].rad;
			q = pipe_s[g].root;
			for (int k = 0; k < BS; k++) begin
				r = {r[47:0], rad[47:46]};
				rad = {rad[45:0], 2'b00};
				trial = {24'd0, q, 2'b01};
				if (r >= trial) begin
					r = r - trial;
					q = {q[22:0], 1'b1};
				end else begin
					q = {q[22:0], 1'b0};
				end
			end
			next_s[g+1].rem = r;
			next_s[g+1].rad = rad;
			next_s[g+1].root = q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NS; i++) pipe_s[i] <= '0;
		end else if (advance) begin
			for (int i = 0; i <= NS; i++) pipe_s[i] <= next_s[i];
		end
	end

	// last stage register feeds the round and pack stage
	logic [31:0] packed_res;
	always_comb begin
		logic [24:0] rt;
		rt = {1'b0, pipe_s[NS].root}
			+ 25'(pipe_s[NS].rem > {26'd0, pipe_s[NS].root});
		// carry out of the significand bumps the exponent
		packed_res = ({1'b0, pipe_s[NS].ebiased, 23'd0})
			+ {7'd0, rt} - 32'h0080_0000;
		if (pipe_s[NS].kind == fsqrt_pkg::KIND_FIXED) packed_res = pipe_s[NS].fixed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_valid <= 1'b0;
		end else if (advance) begin
			root_valid <= pipe_s[NS].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			root_bits    <= packed_res;
			invalid_flag <= pipe_s[NS].inv;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root_stall |=> root_valid && $stable(root_bits))
		else $error("held result word changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && invalid_flag |-> root_bits[30:22] == 9'h1ff)
		else $error("invalid result is not a quiet nan");
	assert property (@(posedge clk) disable iff (!arst_n)
		operand_bits_stall == (root_valid && root_stall))
		else $error("stall does not follow output backpressure");
endmodule
`default_nettype wire
